### hw/rtl/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared widths, codes, types and the edge mask function of the 4bpp
// rectangle fill blitter.
// ----------------------------------------------------------------------------
package rfb_pkg;

  // video store geometry, word address wraps modulo the store size
  localparam int STORE_AW    = 16;
  localparam int STORE_WORDS = 1 << STORE_AW;
  localparam int WORD_W      = 16;

  localparam int COORD_W   = 10;
  localparam int WIDX_W    = COORD_W - 2;  // word index within a row (x >> 2)
  localparam int BASE_W    = 16;
  localparam int PITCH_W   = 9;
  localparam int PROD_W    = COORD_W + PITCH_W;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [OP_W-1:0] OP_FILL  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH = 2'd1;

  localparam logic [BASE_W-1:0]  BASE_RESET  = 16'h0000;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 9'd128;

  localparam logic [WORD_W-1:0] ALL_ONES = 16'hFFFF;

  // commands to the shared address unit
  typedef struct packed {
    logic mul;       // latch first row * pitch
    logic row_init;  // row base = base + product
    logic row_step;  // row base = row base + pitch
    logic word;      // word address = row base + word index
  } au_cmd_t;

  // nibble mask covering pixels lo..hi of one word
  function automatic logic [WORD_W-1:0] span_mask(input logic [1:0] lo,
                                                  input logic [1:0] hi);
    logic [WORD_W-1:0] m_lo;
    logic [WORD_W-1:0] m_hi;
    m_lo = ALL_ONES << {lo, 2'b00};
    m_hi = ALL_ONES >> {~hi, 2'b00};
    return m_lo & m_hi;
  endfunction

endpackage

### hw/rtl/rfb_ram.sv
// ----------------------------------------------------------------------------
// rfb_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rfb_addr_unit.sv
// ----------------------------------------------------------------------------
// rfb_addr_unit
// Shared address unit: one registered multiply for the first row offset and
// one adder reused for the row base, the row step and each word address.
// ----------------------------------------------------------------------------
module rfb_addr_unit (
  input  logic                          clk,
  input  rfb_pkg::au_cmd_t              cmd,
  input  logic [rfb_pkg::COORD_W-1:0]   y_first,
  input  logic [rfb_pkg::PITCH_W-1:0]   pitch,
  input  logic [rfb_pkg::BASE_W-1:0]    base,
  input  logic [rfb_pkg::WIDX_W-1:0]    widx,
  output logic [rfb_pkg::STORE_AW-1:0]  sum,
  output logic [rfb_pkg::STORE_AW-1:0]  addr
);
  import rfb_pkg::*;

  logic [PROD_W-1:0]   prod_r;
  logic [STORE_AW-1:0] row_r;
  logic [STORE_AW-1:0] addr_r;
  logic [STORE_AW-1:0] op_a;
  logic [STORE_AW-1:0] op_b;

  always_comb begin
    op_a = cmd.row_init ? STORE_AW'(base) : row_r;
    if (cmd.row_init) begin
      op_b = STORE_AW'(prod_r);
    end else if (cmd.row_step) begin
      op_b = STORE_AW'(pitch);
    end else begin
      op_b = STORE_AW'(widx);
    end
  end

  // modulo store size falls out of the truncated add
  assign sum = op_a + op_b;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(y_first) * PROD_W'(pitch);
    end
    if (cmd.row_init || cmd.row_step) begin
      row_r <= sum;
    end
    if (cmd.word) begin
      addr_r <= sum;
    end
  end

  assign addr = addr_r;

endmodule

### hw/rtl/rfb_seq.sv
// ----------------------------------------------------------------------------
// rfb_seq
// Command sequencer: store clearing pass, single word access and the
// read-modify-write walk over a fill rectangle.
// ----------------------------------------------------------------------------
module rfb_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rfb_pkg::OP_W-1:0]      in_opcode,
  input  logic [rfb_pkg::COORD_W-1:0]   in_x_min,
  input  logic [rfb_pkg::COORD_W-1:0]   in_y_min,
  input  logic [rfb_pkg::COORD_W-1:0]   in_x_max,
  input  logic [rfb_pkg::COORD_W-1:0]   in_y_max,
  input  logic [rfb_pkg::WORD_W-1:0]    in_color_pattern,
  input  logic [rfb_pkg::WORD_W-1:0]    in_word_address,
  input  logic [rfb_pkg::WORD_W-1:0]    in_write_data,
  output logic                          out_valid,
  output logic [rfb_pkg::WORD_W-1:0]    out_read_data,
  output logic                          out_bad_rect,
  output rfb_pkg::au_cmd_t              au_cmd,
  output logic [rfb_pkg::WIDX_W-1:0]    au_widx,
  input  logic [rfb_pkg::STORE_AW-1:0]  au_sum,
  input  logic [rfb_pkg::STORE_AW-1:0]  au_addr,
  output logic                          ram_we,
  output logic [rfb_pkg::STORE_AW-1:0]  ram_waddr,
  output logic [rfb_pkg::WORD_W-1:0]    ram_wdata,
  output logic                          ram_re,
  output logic [rfb_pkg::STORE_AW-1:0]  ram_raddr,
  input  logic [rfb_pkg::WORD_W-1:0]    ram_rdata
);
  import rfb_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_ROW0  = 6'b000100,
    ST_ADDR  = 6'b001000,
    ST_RMW   = 6'b010000,
    ST_RDOUT = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [WIDX_W-1:0]   w_r, w_nxt;
  logic [WIDX_W-1:0]   w0_r, w0_nxt;
  logic [WIDX_W-1:0]   w1_r, w1_nxt;
  logic [1:0]          lo_r, lo_nxt;
  logic [1:0]          hi_r, hi_nxt;
  logic [COORD_W-1:0]  y_r, y_nxt;
  logic [COORD_W-1:0]  y1_r, y1_nxt;
  logic [WORD_W-1:0]   color_r, color_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_rd_r, out_rd_nxt;
  logic                out_bad_r, out_bad_nxt;

  logic                accept;
  logic                rect_bad;
  logic                last_w;
  logic [1:0]          m_lo;
  logic [1:0]          m_hi;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   merged;

  assign accept   = start && (state_r == ST_IDLE);
  assign rect_bad = (in_x_max < in_x_min) || (in_y_max < in_y_min);
  assign last_w   = (w_r == w1_r);

  // edge mask of the current word
  assign m_lo   = (w_r == w0_r) ? lo_r : 2'd0;
  assign m_hi   = last_w ? hi_r : 2'd3;
  assign mask   = span_mask(m_lo, m_hi);
  assign merged = (ram_rdata & ~mask) | (color_r & mask);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    w_nxt         = w_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    y_nxt         = y_r;
    y1_nxt        = y1_r;
    color_nxt     = color_r;
    out_valid_nxt = 1'b0;
    out_rd_nxt    = out_rd_r;
    out_bad_nxt   = out_bad_r;
    au_cmd        = '0;
    ram_we        = 1'b0;
    ram_waddr     = au_addr;
    ram_wdata     = merged;
    ram_re        = 1'b0;
    ram_raddr     = au_sum;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == STORE_AW'(STORE_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_waddr = STORE_AW'(in_word_address);
        ram_wdata = in_write_data;
        ram_raddr = STORE_AW'(in_word_address);
        if (accept) begin
          out_rd_nxt  = '0;
          out_bad_nxt = 1'b0;
          case (in_opcode)
            OP_FILL: begin
              if (rect_bad) begin
                out_valid_nxt = 1'b1;
                out_bad_nxt   = 1'b1;
              end else begin
                au_cmd.mul = 1'b1;
                w_nxt      = in_x_min[COORD_W-1:2];
                w0_nxt     = in_x_min[COORD_W-1:2];
                w1_nxt     = in_x_max[COORD_W-1:2];
                lo_nxt     = in_x_min[1:0];
                hi_nxt     = in_x_max[1:0];
                y_nxt      = in_y_min;
                y1_nxt     = in_y_max;
                color_nxt  = in_color_pattern;
                state_nxt  = ST_ROW0;
              end
            end
            OP_WRITE: begin
              ram_we        = 1'b1;
              out_valid_nxt = 1'b1;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              state_nxt = ST_RDOUT;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_ROW0: begin
        au_cmd.row_init = 1'b1;
        state_nxt       = ST_ADDR;
      end
      ST_ADDR: begin
        // read issued straight from the adder, address kept for the write
        au_cmd.word = 1'b1;
        ram_re      = 1'b1;
        state_nxt   = ST_RMW;
      end
      ST_RMW: begin
        ram_we    = 1'b1;
        state_nxt = ST_ADDR;
        if (!last_w) begin
          w_nxt = w_r + 1'b1;
        end else if (y_r != y1_r) begin
          au_cmd.row_step = 1'b1;
          w_nxt           = w0_r;
          y_nxt           = y_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RDOUT: begin
        out_valid_nxt = 1'b1;
        out_rd_nxt    = ram_rdata;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r      <= w_nxt;
    w0_r     <= w0_nxt;
    w1_r     <= w1_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    y_r      <= y_nxt;
    y1_r     <= y1_nxt;
    color_r  <= color_nxt;
    out_rd_r <= out_rd_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign au_widx       = w_r;
  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_bad_rect  = out_bad_r;

endmodule

### hw/rtl/rect_fill_blitter_4bpp.sv
// ----------------------------------------------------------------------------
// rect_fill_blitter_4bpp
// Rectangle fill blitter over a 4bpp video store of 16-bit words, with
// single word write and read commands.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  command  | start / busy           | in_opcode, in_x/y_min/max, in_color_
//           |                        | pattern, in_word_address, in_write_data
//  result   | out_valid (one cycle)  | out_read_data, out_bad_rect
//  config   | cfg_we                 | cfg_index, cfg_wdata
//
//  after reset the store is cleared one word a cycle, with busy held high
//  single word write, reversed fill and unused opcode: result next cycle
//  single word read: result via the registered store read and result register
//  fill: one store read and one write per covered word through the single
//  store read/write port pair
//  the result strobe lasts one cycle and cannot be held off
// ----------------------------------------------------------------------------
module rect_fill_blitter_4bpp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rfb_pkg::OP_W-1:0]      in_opcode,
  input  logic [rfb_pkg::COORD_W-1:0]   in_x_min,
  input  logic [rfb_pkg::COORD_W-1:0]   in_y_min,
  input  logic [rfb_pkg::COORD_W-1:0]   in_x_max,
  input  logic [rfb_pkg::COORD_W-1:0]   in_y_max,
  input  logic [rfb_pkg::WORD_W-1:0]    in_color_pattern,
  input  logic [rfb_pkg::WORD_W-1:0]    in_word_address,
  input  logic [rfb_pkg::WORD_W-1:0]    in_write_data,
  output logic                          out_valid,
  output logic [rfb_pkg::WORD_W-1:0]    out_read_data,
  output logic                          out_bad_rect,
  input  logic                          cfg_we,
  input  logic [rfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfb_pkg::CFG_W-1:0]     cfg_wdata
);
  import rfb_pkg::*;

  logic [BASE_W-1:0]   base_r;
  logic [PITCH_W-1:0]  pitch_r;

  au_cmd_t             au_cmd;
  logic [WIDX_W-1:0]   au_widx;
  logic [STORE_AW-1:0] au_sum;
  logic [STORE_AW-1:0] au_addr;

  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [STORE_AW-1:0] ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  // configuration registers, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RESET;
      pitch_r <= PITCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:  base_r  <= cfg_wdata[BASE_W-1:0];
        REG_PITCH: pitch_r <= cfg_wdata[PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfb_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_x_min         (in_x_min),
    .in_y_min         (in_y_min),
    .in_x_max         (in_x_max),
    .in_y_max         (in_y_max),
    .in_color_pattern (in_color_pattern),
    .in_word_address  (in_word_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_bad_rect     (out_bad_rect),
    .au_cmd           (au_cmd),
    .au_widx          (au_widx),
    .au_sum           (au_sum),
    .au_addr          (au_addr),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  rfb_addr_unit u_au (
    .clk     (clk),
    .cmd     (au_cmd),
    .y_first (in_y_min),
    .pitch   (pitch_r),
    .base    (base_r),
    .widx    (au_widx),
    .sum     (au_sum),
    .addr    (au_addr)
  );

  rfb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### hw/rtl/rfb_checker.sv
// ----------------------------------------------------------------------------
// rfb_checker
// Port level checks of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module rfb_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [rfb_pkg::OP_W-1:0]      in_opcode,
  input  logic [rfb_pkg::COORD_W-1:0]   in_x_min,
  input  logic [rfb_pkg::COORD_W-1:0]   in_y_min,
  input  logic [rfb_pkg::COORD_W-1:0]   in_x_max,
  input  logic [rfb_pkg::COORD_W-1:0]   in_y_max,
  input  logic                          out_valid,
  input  logic [rfb_pkg::WORD_W-1:0]    out_read_data,
  input  logic                          out_bad_rect
);
  import rfb_pkg::*;

  // clearing pass holds the block off right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("no clearing pass after reset");

  // every accepted beat either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted beat neither answered nor in progress");

  a_bad_rect_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == OP_FILL &&
    (in_x_max < in_x_min || in_y_max < in_y_min)
    |=> out_valid && out_bad_rect && !busy)
    else $error("reversed rectangle not flagged at once");

  a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_rect |-> out_read_data == '0)
    else $error("flagged result carries read data");

endmodule

bind rect_fill_blitter_4bpp rfb_checker u_rfb_checker (.*);
